[design/line_segment_window_clipper_core_assert.svh]
// Assertion macros shared by the clipper RTL.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_CORE_ASSERT_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/lsc_pkg.sv]
// Shared types and constants of the segment clipper.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsc_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MAG_W       = COORD_W;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int QUO_W       = 35;
  localparam int HI_W        = PROD_W - QUO_W;
  localparam int RES_W       = QUO_W + 1;
  localparam int DIV_STAGES  = QUO_W;
  localparam int LANE_LAT    = DIV_STAGES + 3;
  localparam int NUM_LANES   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  // region code of one axis
  localparam logic [1:0] RC_NONE = 2'd0;
  localparam logic [1:0] RC_LOW  = 2'd1;
  localparam logic [1:0] RC_HIGH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd3;

  // crossing lanes: vertical / horizontal edge for each endpoint
  localparam int LANE_V1 = 0;
  localparam int LANE_H1 = 1;
  localparam int LANE_V2 = 2;
  localparam int LANE_H2 = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } window_t;

  typedef struct packed {
    coord_t     x1;
    coord_t     y1;
    coord_t     x2;
    coord_t     y2;
    logic [1:0] cx1;
    logic [1:0] cy1;
    logic [1:0] cx2;
    logic [1:0] cy2;
    logic       reject;
    diff_t      dx;
    diff_t      dy;
    diff_t      fl;
    diff_t      fr;
    diff_t      fb;
    diff_t      ft;
  } item_t;

  typedef struct packed {
    logic [MAG_W-1:0] nm;
    logic [MAG_W-1:0] fm;
    logic [MAG_W-1:0] dm;
    logic             neg;
    coord_t           base;
  } lane_op_t;

  typedef struct packed {
    res_t v;
    logic fail;
  } lane_res_t;

endpackage

`default_nettype wire

[design/lsc_seg_if.sv]
// Input channel of the clipper: one segment per transaction.
// Uses lsc_pkg for the coordinate width.
`default_nettype none

interface lsc_seg_if;
  import lsc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

[design/lsc_clip_if.sv]
// Output channel of the clipper: one clipped segment per transaction.
// Uses lsc_pkg for the coordinate width.
`default_nettype none

interface lsc_clip_if;
  import lsc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      visible;
  logic signed [COORD_W-1:0] clipped_start_x;
  logic signed [COORD_W-1:0] clipped_start_y;
  logic signed [COORD_W-1:0] clipped_end_x;
  logic signed [COORD_W-1:0] clipped_end_y;

  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                clipped_end_x, clipped_end_y, output ready);
endinterface

`default_nettype wire

[design/line_segment_window_clipper_core.sv]
// Line segment window clipper (Cohen-Sutherland style), top level.
// Uses lsc_pkg, lsc_seg_if, lsc_clip_if, lsc_front, lsc_queue, lsc_back.
//
// Takes one segment per transaction on seg_i and returns one result per
// segment on clip_o, in order. Throughput is one segment per clock unless
// clip_o stalls. Each segment passes the crossing lanes: one 32x32 multiply
// stage, one setup stage, a 35-stage restoring divider (one quotient bit
// per stage) and an offset stage. Four lanes work in parallel, covering the
// vertical and horizontal edge of both endpoints; the corner rule (vertical
// edge first) is applied when the results are picked. A two-entry queue
// sits between the classifier and the lanes so input and output stall
// independently. Window registers are written through cfg_* while the block
// is idle, a rule for the user that the block does not enforce; they reset
// to zero. A rejected segment comes back echoed, with visible low.
`default_nettype none

module line_segment_window_clipper_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsc_pkg::COORD_W-1:0]      cfg_data_i,
  lsc_seg_if.sink                          seg_i,
  lsc_clip_if.source                       clip_o
);
  import lsc_pkg::*;

  window_t win_q;
  item_t   f_item, q_item;
  logic    push, full, q_valid, pop;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEFT: begin
          win_q.left <= cfg_data_i;
        end
        CFG_RIGHT: begin
          win_q.right <= cfg_data_i;
        end
        CFG_BOTTOM: begin
          win_q.bottom <= cfg_data_i;
        end
        CFG_TOP: begin
          win_q.top <= cfg_data_i;
        end
      endcase
    end
  end

  // classify: region codes, trivial reject, differences
  lsc_front u_front (
    .seg_i  (seg_i),
    .win_i  (win_q),
    .full_i (full),
    .push_o (push),
    .item_o (f_item)
  );

  // decouples input acceptance from pipeline stalls
  lsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // crossings, endpoint selection, result register
  lsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_i     (win_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .clip_o    (clip_o)
  );

endmodule

`default_nettype wire

[design/lsc_front.sv]
// Front end: region codes, trivial reject and edge differences of a segment.
// Uses lsc_pkg and lsc_seg_if; feeds lsc_queue.
`default_nettype none

module lsc_front (
  lsc_seg_if.sink          seg_i,
  input  lsc_pkg::window_t win_i,
  input  logic             full_i,
  output logic             push_o,
  output lsc_pkg::item_t   item_o
);
  import lsc_pkg::*;

  function automatic logic [1:0] rcode(coord_t v, coord_t lo, coord_t hi);
    logic [1:0] c;
    if (v < lo) c = RC_LOW;
    else if (v > hi) c = RC_HIGH;
    else c = RC_NONE;
    return c;
  endfunction

  assign seg_i.ready = !full_i;
  assign push_o      = seg_i.valid && !full_i;

  always_comb begin
    item_o.x1  = seg_i.start_x;
    item_o.y1  = seg_i.start_y;
    item_o.x2  = seg_i.end_x;
    item_o.y2  = seg_i.end_y;
    item_o.cx1 = rcode(seg_i.start_x, win_i.left, win_i.right);
    item_o.cy1 = rcode(seg_i.start_y, win_i.bottom, win_i.top);
    item_o.cx2 = rcode(seg_i.end_x, win_i.left, win_i.right);
    item_o.cy2 = rcode(seg_i.end_y, win_i.bottom, win_i.top);
    // both ends beyond the same side: nothing visible, no zero divisor later
    item_o.reject = (item_o.cx1 != RC_NONE && item_o.cx1 == item_o.cx2) ||
                    (item_o.cy1 != RC_NONE && item_o.cy1 == item_o.cy2);
    item_o.dx = diff_t'(seg_i.end_x) - diff_t'(seg_i.start_x);
    item_o.dy = diff_t'(seg_i.end_y) - diff_t'(seg_i.start_y);
    item_o.fl = diff_t'(win_i.left) - diff_t'(seg_i.start_x);
    item_o.fr = diff_t'(win_i.right) - diff_t'(seg_i.start_x);
    item_o.fb = diff_t'(win_i.bottom) - diff_t'(seg_i.start_y);
    item_o.ft = diff_t'(win_i.top) - diff_t'(seg_i.start_y);
  end

endmodule

`default_nettype wire

[design/lsc_queue.sv]
// Two-entry queue between the front end and the crossing pipeline.
// Uses lsc_pkg and the assertion header.
`default_nettype none

`include "line_segment_window_clipper_core_assert.svh"

module lsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lsc_pkg::item_t item_o
);
  import lsc_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `LSC_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `LSC_ASSERT(a_cnt_up, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1, "count missed push")
  `LSC_ASSERT(a_pop_nonempty, pop_i |-> valid_o, "pop from empty queue")

endmodule

`default_nettype wire

[design/lsc_lane.sv]
// One crossing lane: 32x32 product, restoring divider one quotient bit per
// stage, then base offset. Uses lsc_pkg; advances only on en_i.
`default_nettype none

module lsc_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  lsc_pkg::lane_op_t  op_i,
  output lsc_pkg::lane_res_t res_o
);
  import lsc_pkg::*;

  // multiply stage
  logic [PROD_W-1:0] prod_q;
  logic [MAG_W-1:0]  a_d_q;
  logic              a_neg_q;
  coord_t            a_base_q;

  // divider stages, index 0 is the setup stage
  logic [MAG_W-1:0] r_q    [DIV_STAGES+1];
  logic [QUO_W-1:0] lo_q   [DIV_STAGES];
  logic [QUO_W-1:0] q_q    [DIV_STAGES+1];
  logic [MAG_W-1:0] d_q    [DIV_STAGES+1];
  logic             neg_q  [DIV_STAGES+1];
  coord_t           base_q [DIV_STAGES+1];
  logic             ovf_q  [DIV_STAGES+1];

  logic [MAG_W-1:0] hi_part;
  logic [QUO_W-1:0] q_fin;
  res_t             bx, qx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= PROD_W'(op_i.nm) * PROD_W'(op_i.fm);
      a_d_q    <= op_i.dm;
      a_neg_q  <= op_i.neg;
      a_base_q <= op_i.base;
    end
  end

  // quotient >= 2^QUO_W when the top part alone reaches the divisor
  assign hi_part = MAG_W'(prod_q[PROD_W-1 -: HI_W]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= hi_part;
      lo_q[0]   <= prod_q[QUO_W-1:0];
      q_q[0]    <= '0;
      d_q[0]    <= a_d_q;
      neg_q[0]  <= a_neg_q;
      base_q[0] <= a_base_q;
      ovf_q[0]  <= hi_part >= a_d_q;
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [MAG_W:0] t, diff;
    logic           ge;

    assign t    = {r_q[s-1], lo_q[s-1][QUO_W-1]};
    assign diff = t - {1'b0, d_q[s-1]};
    assign ge   = !diff[MAG_W];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
        q_q[s]    <= {q_q[s-1][QUO_W-2:0], ge};
        d_q[s]    <= d_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        base_q[s] <= base_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end

    if (s < DIV_STAGES) begin : g_lo
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[s] <= {lo_q[s-1][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q_fin = q_q[DIV_STAGES];
  assign bx    = RES_W'(base_q[DIV_STAGES]);
  assign qx    = RES_W'(q_fin);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.v    <= neg_q[DIV_STAGES] ? bx - qx : bx + qx;
      res_o.fail <= ovf_q[DIV_STAGES] || (q_fin[QUO_W-1] && |q_fin[QUO_W-2:0]);
    end
  end

  // r_q of the last stage is the remainder, not needed for the crossing
  logic unused_rem;
  assign unused_rem = ^r_q[DIV_STAGES];

endmodule

`default_nettype wire

[design/lsc_back.sv]
// Back end: builds lane operands, runs four crossing lanes, picks endpoints
// and holds the result. Uses lsc_pkg, lsc_lane, lsc_clip_if, assert header.
`default_nettype none

`include "line_segment_window_clipper_core_assert.svh"

module lsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsc_pkg::window_t win_i,
  input  logic             q_valid_i,
  input  lsc_pkg::item_t   q_item_i,
  output logic             pop_o,
  lsc_clip_if.source       clip_o
);
  import lsc_pkg::*;

  typedef struct packed {
    coord_t     x1;
    coord_t     y1;
    coord_t     x2;
    coord_t     y2;
    logic [1:0] cx1;
    logic [1:0] cy1;
    logic [1:0] cx2;
    logic [1:0] cy2;
    logic       reject;
  } side_t;

  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } pt_t;

  function automatic logic [MAG_W-1:0] mag(diff_t d);
    diff_t n;
    n = -d;
    return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  function automatic lane_op_t mk_op(diff_t num, diff_t fac, diff_t den, coord_t base);
    lane_op_t o;
    o.nm   = mag(num);
    o.fm   = mag(fac);
    o.dm   = mag(den);
    o.neg  = num[DIFF_W-1] ^ fac[DIFF_W-1] ^ den[DIFF_W-1];
    o.base = base;
    return o;
  endfunction

  function automatic pt_t clip_pt(logic [1:0] cx, logic [1:0] cy, coord_t px,
                                  coord_t py, lane_res_t rv, lane_res_t rh,
                                  window_t w);
    pt_t    p;
    logic   okv, okh;
    coord_t ex, ey;
    okv = !rv.fail && rv.v >= res_t'(w.bottom) && rv.v <= res_t'(w.top);
    okh = !rh.fail && rh.v >= res_t'(w.left) && rh.v <= res_t'(w.right);
    ex  = (cx == RC_LOW) ? w.left : w.right;
    ey  = (cy == RC_LOW) ? w.bottom : w.top;
    p.ok = 1'b1;
    p.x  = px;
    p.y  = py;
    priority if (cx != RC_NONE && okv) begin
      p.x = ex;
      p.y = rv.v[COORD_W-1:0];
    end else if (cy != RC_NONE && okh) begin
      p.x = rh.v[COORD_W-1:0];
      p.y = ey;
    end else if (cx != RC_NONE || cy != RC_NONE) begin
      p.ok = 1'b0;
    end
    return p;
  endfunction

  logic                en;
  logic [LANE_LAT:0]   vld_q;
  side_t               side_q [LANE_LAT+1];
  lane_op_t            op_d   [NUM_LANES];
  lane_op_t            op_q   [NUM_LANES];
  lane_res_t           res    [NUM_LANES];
  side_t               side_in, sl;
  diff_t               fx1, fy1, fx2, fy2;
  pt_t                 p1, p2;
  logic                vis;

  logic                out_vld_q;
  logic                out_vis_q;
  coord_t              out_sx_q, out_sy_q, out_ex_q, out_ey_q;

  // whole pipeline moves together whenever the result slot frees up
  assign en    = !out_vld_q || clip_o.ready;
  assign pop_o = q_valid_i && en;

  always_comb begin
    fx1 = (q_item_i.cx1 == RC_LOW) ? q_item_i.fl : q_item_i.fr;
    fy1 = (q_item_i.cy1 == RC_LOW) ? q_item_i.fb : q_item_i.ft;
    fx2 = (q_item_i.cx2 == RC_LOW) ? q_item_i.fl : q_item_i.fr;
    fy2 = (q_item_i.cy2 == RC_LOW) ? q_item_i.fb : q_item_i.ft;
    op_d[LANE_V1] = mk_op(q_item_i.dy, fx1, q_item_i.dx, q_item_i.y1);
    op_d[LANE_H1] = mk_op(q_item_i.dx, fy1, q_item_i.dy, q_item_i.x1);
    op_d[LANE_V2] = mk_op(q_item_i.dy, fx2, q_item_i.dx, q_item_i.y1);
    op_d[LANE_H2] = mk_op(q_item_i.dx, fy2, q_item_i.dy, q_item_i.x1);
    side_in.x1     = q_item_i.x1;
    side_in.y1     = q_item_i.y1;
    side_in.x2     = q_item_i.x2;
    side_in.y2     = q_item_i.y2;
    side_in.cx1    = q_item_i.cx1;
    side_in.cy1    = q_item_i.cy1;
    side_in.cx2    = q_item_i.cx2;
    side_in.cy2    = q_item_i.cy2;
    side_in.reject = q_item_i.reject;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-1:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= LANE_LAT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        op_q[l] <= op_d[l];
      end
    end

    lsc_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (op_q[l]),
      .res_o (res[l])
    );
  end

  assign sl  = side_q[LANE_LAT];
  assign p1  = clip_pt(sl.cx1, sl.cy1, sl.x1, sl.y1, res[LANE_V1], res[LANE_H1], win_i);
  assign p2  = clip_pt(sl.cx2, sl.cy2, sl.x2, sl.y2, res[LANE_V2], res[LANE_H2], win_i);
  assign vis = !sl.reject && p1.ok && p2.ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LANE_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_vis_q <= vis;
      out_sx_q  <= vis ? p1.x : sl.x1;
      out_sy_q  <= vis ? p1.y : sl.y1;
      out_ex_q  <= vis ? p2.x : sl.x2;
      out_ey_q  <= vis ? p2.y : sl.y2;
    end
  end

  assign clip_o.valid           = out_vld_q;
  assign clip_o.visible         = out_vis_q;
  assign clip_o.clipped_start_x = out_sx_q;
  assign clip_o.clipped_start_y = out_sy_q;
  assign clip_o.clipped_end_x   = out_ex_q;
  assign clip_o.clipped_end_y   = out_ey_q;

  `LSC_ASSERT(a_hold_on_stall, (out_vld_q && !clip_o.ready) |=> $stable(vld_q), "pipe moved while stalled")
  `LSC_ASSERT(a_out_from_pipe, $rose(out_vld_q) |-> $past(vld_q[LANE_LAT]), "result without item")
  `LSC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_vld_q || rst_ni, "result valid in reset")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for the segment window clipper: directed table, then random segments.
// Depends on lsc_pkg, lsc_seg_if, lsc_clip_if and line_segment_window_clipper_core.
`default_nettype none

module tb_top;
  import lsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one clipped segment as seen on the output channel
  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_seg_t;

  // directed stimulus row; has_exp marks rows whose result is typed in
  typedef struct {
    coord_t    x1;
    coord_t    y1;
    coord_t    x2;
    coord_t    y2;
    bit        has_exp;
    clip_seg_t exp_seg;
  } seg_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_LEFT;
  logic [COORD_W-1:0] cfg_data_i = '0;

  lsc_seg_if  seg_ch ();
  lsc_clip_if clip_ch ();

  line_segment_window_clipper_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .seg_i      (seg_ch.sink),
    .clip_o     (clip_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the window registers
  longint win_left, win_right, win_bottom, win_top;

  clip_seg_t pending_clips[$];
  // typed-in results from the table, checked in addition to the predictor
  clip_seg_t typed_clips[$];
  bit        typed_flag[$];

  int mismatches = 0;
  int clips_seen = 0;
  int visible_seen = 0;
  int segs_sent = 0;
  bit sink_done = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int region_x(longint x);
    if (x < win_left) return 1;
    if (x > win_right) return 2;
    return 0;
  endfunction

  function automatic int region_y(longint y);
    if (y < win_bottom) return 1;
    if (y > win_top) return 2;
    return 0;
  endfunction

  // edge crossing: base + num*fac/den at full precision, truncated toward zero;
  // succeeds only if the result lies in [lo, hi]
  function automatic bit edge_cross(longint base, longint num, longint fac,
                                    longint den, longint lo, longint hi,
                                    output longint res);
    logic [127:0] nm, fm, dm, qm;
    bit neg;
    longint v;
    res = 0;
    if (den == 0) return 0;
    nm = num < 0 ? -num : num;
    fm = fac < 0 ? -fac : fac;
    dm = den < 0 ? -den : den;
    neg = ((num < 0) != (fac < 0)) != (den < 0);
    qm = (nm * fm) / dm;
    // a quotient beyond 2**34 can never land inside a 32-bit window
    if (qm > (128'd1 << 34)) return 0;
    v = neg ? base - longint'(qm) : base + longint'(qm);
    if (v < lo || v > hi) return 0;
    res = v;
    return 1;
  endfunction

  // move one endpoint onto the window; corners try the vertical edge first
  function automatic bit move_endpoint(int cx, int cy, longint x1, longint y1,
                                       longint x2, longint y2,
                                       inout longint px, inout longint py);
    longint v, ex, ey;
    if (cx != 0) begin
      ex = (cx == 1) ? win_left : win_right;
      if (edge_cross(y1, y2 - y1, ex - x1, x2 - x1, win_bottom, win_top, v)) begin
        px = ex;
        py = v;
        return 1;
      end
      if (cy == 0) return 0;
    end
    if (cy != 0) begin
      ey = (cy == 1) ? win_bottom : win_top;
      if (edge_cross(x1, x2 - x1, ey - y1, y2 - y1, win_left, win_right, v)) begin
        px = v;
        py = ey;
        return 1;
      end
      return 0;
    end
    return 1;
  endfunction

  function automatic clip_seg_t clip_segment(coord_t ix1, coord_t iy1,
                                             coord_t ix2, coord_t iy2);
    clip_seg_t r;
    longint x1, y1, x2, y2, ox1, oy1, ox2, oy2;
    int cx1, cy1, cx2, cy2;
    bit vis;
    x1 = ix1; y1 = iy1; x2 = ix2; y2 = iy2;
    ox1 = x1; oy1 = y1; ox2 = x2; oy2 = y2;
    cx1 = region_x(x1); cy1 = region_y(y1);
    cx2 = region_x(x2); cy2 = region_y(y2);
    vis = 1'b1;
    // trivial reject: both ends beyond the same side
    if ((cx1 != 0 && cx1 == cx2) || (cy1 != 0 && cy1 == cy2)) vis = 1'b0;
    if (vis && !move_endpoint(cx1, cy1, x1, y1, x2, y2, ox1, oy1)) vis = 1'b0;
    if (vis && !move_endpoint(cx2, cy2, x1, y1, x2, y2, ox2, oy2)) vis = 1'b0;
    r.visible = vis;
    // rejected segments echo their input
    r.sx = vis ? coord_t'(ox1) : ix1;
    r.sy = vis ? coord_t'(oy1) : iy1;
    r.ex = vis ? coord_t'(ox2) : ix2;
    r.ey = vis ? coord_t'(oy2) : iy2;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration and source side
  // ---------------------------------------------------------------------------

  task automatic write_window(coord_t l, coord_t r, coord_t b, coord_t t);
    logic [CFG_IDX_W-1:0] idx[4];
    coord_t val[4];
    idx = '{CFG_LEFT, CFG_RIGHT, CFG_BOTTOM, CFG_TOP};
    val = '{l, r, b, t};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_left = l; win_right = r; win_bottom = b; win_top = t;
  endtask

  // block is idle once every expected transaction is back plus pipeline slack
  task automatic drain_pipe();
    while (pending_clips.size() != 0) @(posedge clk_i);
    repeat (LANE_LAT + 8) @(posedge clk_i);
  endtask

  // one input transaction; valid is only lowered when a gap precedes it
  task automatic send_segment(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                              bit has_exp, clip_seg_t exp_seg);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 9) < 4) gap = 0;
    if (gap != 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= x1;
    seg_ch.start_y <= y1;
    seg_ch.end_x   <= x2;
    seg_ch.end_y   <= y2;
    pending_clips.push_back(clip_segment(x1, y1, x2, y2));
    typed_flag.push_back(has_exp);
    typed_clips.push_back(exp_seg);
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    segs_sent++;
  endtask

  function automatic coord_t rand_coord(int spread);
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'(int'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic clip_seg_t mk(logic v, coord_t a, coord_t b, coord_t c, coord_t d);
    clip_seg_t r;
    r.visible = v; r.sx = a; r.sy = b; r.ex = c; r.ey = d;
    return r;
  endfunction

  seg_row_t seg_table[$];
  clip_seg_t no_exp;

  initial begin
    coord_t l, r, b, t;
    int spread;
    seg_ch.valid   = 1'b0;
    seg_ch.start_x = '0;
    seg_ch.start_y = '0;
    seg_ch.end_x   = '0;
    seg_ch.end_y   = '0;
    win_left = 0; win_right = 0; win_bottom = 0; win_top = 0;
    no_exp = mk(1'b0, 0, 0, 0, 0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the window is the single point (0,0)
    seg_table = '{
      '{0, 0, 0, 0, 1, mk(1, 0, 0, 0, 0)},
      '{5, 5, 9, 9, 1, mk(0, 5, 5, 9, 9)},
      '{-4, 0, 4, 0, 1, mk(1, 0, 0, 0, 0)},
      '{0, -7, 0, 7, 1, mk(1, 0, 0, 0, 0)},
      '{-3, -3, 3, 3, 0, no_exp},
      '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, no_exp},
      '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, no_exp}
    };
    foreach (seg_table[i])
      send_segment(seg_table[i].x1, seg_table[i].y1, seg_table[i].x2,
                   seg_table[i].y2, seg_table[i].has_exp, seg_table[i].exp_seg);
    seg_ch.valid <= 1'b0;
    drain_pipe();

    // ordinary window: inside, trivial rejects, each corner, failed crossings
    write_window(-100, 100, -50, 50);
    seg_table = '{
      '{-10, -10, 10, 10, 1, mk(1, -10, -10, 10, 10)},
      '{-200, 0, -150, 10, 1, mk(0, -200, 0, -150, 10)},
      '{200, 0, 300, 10, 1, mk(0, 200, 0, 300, 10)},
      '{0, -60, 5, -90, 1, mk(0, 0, -60, 5, -90)},
      '{0, 60, 5, 90, 1, mk(0, 0, 60, 5, 90)},
      '{-200, 0, 200, 0, 1, mk(1, -100, 0, 100, 0)},
      '{0, -100, 0, 100, 1, mk(1, 0, -50, 0, 50)},
      '{-200, -200, 200, 200, 0, no_exp},
      '{-200, 200, 200, -200, 0, no_exp},
      '{-150, 60, -90, 200, 0, no_exp},
      '{-120, -60, 0, 0, 0, no_exp},
      '{32'sh80000000, 7, 32'sh7fffffff, -9, 0, no_exp},
      '{3, 32'sh80000000, -3, 32'sh7fffffff, 0, no_exp}
    };
    foreach (seg_table[i])
      send_segment(seg_table[i].x1, seg_table[i].y1, seg_table[i].x2,
                   seg_table[i].y2, seg_table[i].has_exp, seg_table[i].exp_seg);

    // sender holds off until the pipeline is empty
    seg_ch.valid <= 1'b0;
    drain_pipe();

    // extreme and inverted windows
    write_window(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_segment(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1,
                 mk(1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    seg_ch.valid <= 1'b0;
    drain_pipe();
    write_window(50, -50, 40, -40);
    send_segment(0, 0, 60, 60, 0, no_exp);
    send_segment(-60, 45, 70, -45, 0, no_exp);
    seg_ch.valid <= 1'b0;
    drain_pipe();

    // random phases, each with a fresh window
    for (int ph = 0; ph < 12; ph++) begin
      spread = (ph % 3 == 0) ? 1000 : (ph % 3 == 1) ? 100000 : 2000000000;
      case (ph % 4)
        0: begin l = 32'sh80000000; r = 32'sh7fffffff; b = -300; t = 300; end
        3: begin
          l = coord_t'($urandom); r = coord_t'($urandom);
          b = coord_t'($urandom); t = coord_t'($urandom);
        end
        default: begin
          l = rand_coord(spread / 2); r = l + coord_t'($urandom_range(0, spread));
          b = rand_coord(spread / 2); t = b + coord_t'($urandom_range(0, spread));
        end
      endcase
      write_window(l, r, b, t);
      for (int k = 0; k < 120; k++)
        send_segment(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                     rand_coord(spread), 0, no_exp);
      seg_ch.valid <= 1'b0;
      drain_pipe();
    end
    sink_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // sink side: random stalls and checking
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  initial clip_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    clip_seg_t want;
    bit typed;
    clip_seg_t typed_seg;
    if (clip_ch.valid && clip_ch.ready) begin
      clips_seen++;
      if (clip_ch.visible) visible_seen++;
      if (pending_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction at %0t: got %0b (%0d,%0d)-(%0d,%0d)",
                   $realtime, clip_ch.visible, clip_ch.clipped_start_x,
                   clip_ch.clipped_start_y, clip_ch.clipped_end_x,
                   clip_ch.clipped_end_y);
      end else begin
        want = pending_clips.pop_front();
        typed = typed_flag.pop_front();
        typed_seg = typed_clips.pop_front();
        if (typed && want != typed_seg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row: exp %0b (%0d,%0d)-(%0d,%0d) predictor %0b (%0d,%0d)-(%0d,%0d)",
                     typed_seg.visible, typed_seg.sx, typed_seg.sy, typed_seg.ex,
                     typed_seg.ey, want.visible, want.sx, want.sy, want.ex, want.ey);
        end
        if (clip_ch.visible !== want.visible || clip_ch.clipped_start_x !== want.sx ||
            clip_ch.clipped_start_y !== want.sy || clip_ch.clipped_end_x !== want.ex ||
            clip_ch.clipped_end_y !== want.ey) begin
          mismatches++;
          if (mismatches <= 10)
            $display("clip error: exp %0b (%0d,%0d)-(%0d,%0d) got %0b (%0d,%0d)-(%0d,%0d)",
                     want.visible, want.sx, want.sy, want.ex, want.ey,
                     clip_ch.visible, clip_ch.clipped_start_x, clip_ch.clipped_start_y,
                     clip_ch.clipped_end_x, clip_ch.clipped_end_y);
        end
      end
    end
    // stall draw: per transaction, with long no-stall stretches
    if (stall_left > 0) begin
      stall_left--;
      clip_ch.ready <= (stall_left == 0);
    end else if (clip_ch.valid && clip_ch.ready) begin
      stall_left = ((clips_seen / 200) % 2 == 0) ? 0 : $urandom_range(0, 16);
      clip_ch.ready <= (stall_left == 0);
    end else if (!clip_ch.ready) begin
      clip_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------

  initial begin
    wait (sink_done);
    repeat (LANE_LAT + 20) @(posedge clk_i);
    if (pending_clips.size() != 0) mismatches++;
    $display("%0d segments clipped against 16 windows, %0d came back visible",
             clips_seen, visible_seen);
    if (mismatches == 0) begin
      $display("line_segment_window_clipper_core: match");
    end else begin
      $display("line_segment_window_clipper_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("line_segment_window_clipper_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
